// ===== sv/ftg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftg_pkg
// Shared constants and the gamma threshold function for the filmic tone
// mapper.
// ----------------------------------------------------------------------------
package ftg_pkg;

    localparam int unsigned IN_BITS_DEF  = 16;
    localparam int unsigned OUT_BITS_DEF = 8;

    localparam int unsigned GAIN_W     = 16;
    localparam int unsigned GAIN_RESET = 4710;

    localparam int unsigned X_FRAC    = 20;
    localparam int unsigned TONE_FRAC = 16;
    localparam int unsigned F_W       = TONE_FRAC + 1;

    localparam int unsigned CURVE_NUM_SQ  = 251;
    localparam int unsigned CURVE_NUM_LIN = 3;
    localparam int unsigned CURVE_DEN_SQ  = 243;
    localparam int unsigned CURVE_DEN_LIN = 59;
    localparam int unsigned CURVE_DEN_K   = 14;

    localparam int unsigned GAMMA_NUM = 5;
    localparam int unsigned GAMMA_DEN = 11;

    // exposure, square partials, square sum, curve terms, divider setup,
    // one divider stage per quotient bit, saturation
    localparam int unsigned TONE_LAT = 5 + F_W + 1;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-3:0] REG_GAIN_IDX = '0;

    localparam int unsigned GW = 320;

    // Smallest tone value F (Q1.16) whose encoded code reaches c.
    function automatic logic [F_W-1:0] gamma_threshold(input int unsigned c,
                                                       input int unsigned out_bits);
        logic [GW-1:0]  p;
        logic [GW-1:0]  r;
        logic [GW-1:0]  t;
        logic [F_W-1:0] lo;
        logic [F_W-1:0] hi;
        logic [F_W-1:0] mid;
        logic [F_W:0]   sum;
        int unsigned    m;
        int unsigned    k;
        if (c == 0) begin
            return '0;
        end
        m = (32'd1 << out_bits) - 1;
        p = GW'(1);
        for (k = 0; k < GAMMA_DEN; k++) begin
            p = p * GW'(2 * m);
        end
        r = GW'(1);
        for (k = 0; k < GAMMA_DEN; k++) begin
            r = r * GW'(2 * c - 1);
        end
        r = r << (GAMMA_NUM * TONE_FRAC);
        lo = '0;
        hi = F_W'(1) << TONE_FRAC;
        while (lo < hi) begin
            sum = {1'b0, lo} + {1'b0, hi};
            mid = sum[F_W:1];
            t = GW'(1);
            for (k = 0; k < GAMMA_NUM; k++) begin
                t = t * GW'(mid);
            end
            t = t * p;
            if (t >= r) begin
                hi = mid;
            end else begin
                lo = mid + F_W'(1);
            end
        end
        return hi;
    endfunction

endpackage
`default_nettype wire

// ===== sv/filmic_tonemap_gamma.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// filmic_tonemap_gamma
// Filmic tone mapping with gamma 1/2.2 encoding of a linear RGB pixel.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while s_tready is high and returns one pixel of
// three codes for each, in order. The three channels run in parallel lanes;
// a pixel passes through the 17-stage restoring divider of the tone curve
// and the one stage per code bit of the gamma search. s_tready is registered
// and drops only while the two-word output buffer is full. exposure_gain sits
// at address 0 and resets to 4710 (1.15 in Q4.12); the user must write it
// only while idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module filmic_tonemap_gamma #(
    parameter  int IN_BITS  = ftg_pkg::IN_BITS_DEF,
    parameter  int OUT_BITS = ftg_pkg::OUT_BITS_DEF,
    localparam int IN_W     = ((3 * IN_BITS + 7) / 8) * 8,
    localparam int OUT_W    = ((3 * OUT_BITS + 7) / 8) * 8
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // red_linear, green_linear, blue_linear
    input  wire logic [IN_W-1:0]                s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // red_code, green_code, blue_code
    output logic [OUT_W-1:0]                    m_tdata,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ftg_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [ftg_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [ftg_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import ftg_pkg::*;

    localparam int LAT = TONE_LAT + OUT_BITS;

    logic [GAIN_W-1:0]   gain_reg, gain_next;
    logic [LAT-1:0]      vld_reg;
    logic                en;
    logic [F_W-1:0]      tone_w [0:2];
    logic [OUT_BITS-1:0] code_w [0:2];
    logic [OUT_W-1:0]    pix_w;
    logic                cfg_wr;

    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[CFG_ADDR_W-1:2] == REG_GAIN_IDX);

    always_comb begin
        gain_next = gain_reg;
        if (cfg_wr) begin
            gain_next = pwdata[GAIN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= GAIN_W'(GAIN_RESET);
        end else begin
            gain_reg <= gain_next;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_GAIN_IDX) ? CFG_DATA_W'(gain_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    assign s_tready = en;

    for (genvar l = 0; l < 3; l++) begin : g_lane
        ftg_tone #(
            .IN_BITS (IN_BITS)
        ) u_tone (
            .aclk (aclk),
            .en   (en),
            .lin  (s_tdata[l*IN_BITS +: IN_BITS]),
            .gain (gain_reg),
            .tone (tone_w[l])
        );

        ftg_gamma #(
            .OUT_BITS (OUT_BITS)
        ) u_gamma (
            .aclk (aclk),
            .en   (en),
            .tone (tone_w[l]),
            .code (code_w[l])
        );
    end

    assign pix_w = OUT_W'({code_w[2], code_w[1], code_w[0]});

    ftg_merge #(
        .DATA_W (OUT_W)
    ) u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (vld_reg[LAT-1]),
        .in_ready (en),
        .in_data  (pix_w),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_data   (m_tdata)
    );

endmodule
`default_nettype wire

// ===== sv/ftg_tone.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftg_tone
// One channel lane: exposure scaling, filmic curve terms and a pipelined
// restoring divider that yields the rounded, saturated Q1.16 tone value.
// ----------------------------------------------------------------------------
module ftg_tone #(
    parameter int IN_BITS = ftg_pkg::IN_BITS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      en,
    input  wire logic [IN_BITS-1:0]        lin,
    input  wire logic [ftg_pkg::GAIN_W-1:0] gain,
    output logic [ftg_pkg::F_W-1:0]        tone
);
    import ftg_pkg::*;

    localparam int XW   = IN_BITS + GAIN_W;
    localparam int H    = XW / 2;
    localparam int HW   = XW - H;
    localparam int SW   = 2 * XW;
    localparam int NUMW = SW + 9;
    localparam int DENW = SW + 9;
    localparam int RW   = DENW + 19;
    localparam int QB   = F_W;

    logic [XW-1:0]     x_reg;
    logic [XW-1:0]     xb_reg;
    logic [XW-1:0]     xc_reg;
    logic [2*HW-1:0]   hh_reg;
    logic [HW+H-1:0]   hl_reg;
    logic [2*H-1:0]    ll_reg;
    logic [SW-1:0]     s_reg;
    logic [NUMW-1:0]   num_reg;
    logic [DENW-1:0]   den_reg;
    logic [RW-1:0]     rem_reg [0:QB];
    logic [DENW:0]     dv_reg  [0:QB];
    logic [QB-1:0]     q_reg   [0:QB];
    logic [F_W-1:0]    f_reg;

    logic [NUMW-1:0]   num_next;
    logic [DENW-1:0]   den_next;
    logic [RW:0]       trial   [0:QB-1];
    logic [F_W-1:0]    f_next;

    always_comb begin
        num_next = NUMW'(s_reg) * NUMW'(CURVE_NUM_SQ)
                 + ((NUMW'(xc_reg) * NUMW'(CURVE_NUM_LIN)) << X_FRAC);
        den_next = DENW'(s_reg) * DENW'(CURVE_DEN_SQ)
                 + ((DENW'(xc_reg) * DENW'(CURVE_DEN_LIN)) << X_FRAC)
                 + (DENW'(CURVE_DEN_K) << (2 * X_FRAC));
        for (int i = 0; i < QB; i++) begin
            trial[i] = {1'b0, rem_reg[i]} - {1'b0, RW'(dv_reg[i]) << (QB - 1 - i)};
        end
        if (q_reg[QB] > QB'(F_W'(1) << TONE_FRAC)) begin
            f_next = F_W'(1) << TONE_FRAC;
        end else begin
            f_next = F_W'(q_reg[QB]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg   <= XW'(lin) * XW'(gain);
            xb_reg  <= x_reg;
            hh_reg  <= (2*HW)'(x_reg[XW-1:H]) * (2*HW)'(x_reg[XW-1:H]);
            hl_reg  <= (HW+H)'(x_reg[XW-1:H]) * (HW+H)'(x_reg[H-1:0]);
            ll_reg  <= (2*H)'(x_reg[H-1:0]) * (2*H)'(x_reg[H-1:0]);
            xc_reg  <= xb_reg;
            s_reg   <= (SW'(hh_reg) << (2 * H)) + (SW'(hl_reg) << (H + 1)) + SW'(ll_reg);
            num_reg <= num_next;
            den_reg <= den_next;
            rem_reg[0] <= (RW'(num_reg) << QB) + RW'(den_reg);
            dv_reg[0]  <= {den_reg, 1'b0};
            q_reg[0]   <= '0;
            for (int i = 0; i < QB; i++) begin
                rem_reg[i+1] <= trial[i][RW] ? rem_reg[i] : trial[i][RW-1:0];
                dv_reg[i+1]  <= dv_reg[i];
                q_reg[i+1]   <= {q_reg[i][QB-2:0], ~trial[i][RW]};
            end
            f_reg <= f_next;
        end
    end

    assign tone = f_reg;

endmodule
`default_nettype wire

// ===== sv/ftg_gamma.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftg_gamma
// One channel lane: gamma 1/2.2 encoding as a pipelined binary search over
// a constant table of code thresholds, one code bit per stage.
// ----------------------------------------------------------------------------
module ftg_gamma #(
    parameter int OUT_BITS = ftg_pkg::OUT_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   en,
    input  wire logic [ftg_pkg::F_W-1:0] tone,
    output logic [OUT_BITS-1:0]         code
);
    import ftg_pkg::*;

    localparam int OB = OUT_BITS;
    localparam int TN = 2 ** OUT_BITS;

    logic [F_W-1:0] thr    [0:TN-1];
    logic [OB-1:0]  c_reg  [1:OB];
    logic [F_W-1:0] f_reg  [1:OB-1];
    logic [OB-1:0]  c_cur  [0:OB-1];
    logic [F_W-1:0] f_cur  [0:OB-1];
    logic [OB-1:0]  cand   [0:OB-1];
    logic [OB-1:0]  take;

    for (genvar g = 0; g < TN; g++) begin : g_thr
        localparam logic [F_W-1:0] T = gamma_threshold(g, OUT_BITS);
        assign thr[g] = T;
    end

    always_comb begin
        c_cur[0] = '0;
        f_cur[0] = tone;
        for (int i = 1; i < OB; i++) begin
            c_cur[i] = c_reg[i];
            f_cur[i] = f_reg[i];
        end
        for (int i = 0; i < OB; i++) begin
            cand[i] = c_cur[i] | (OB'(1) << (OB - 1 - i));
            take[i] = f_cur[i] >= thr[cand[i]];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < OB; i++) begin
                c_reg[i+1] <= take[i] ? cand[i] : c_cur[i];
            end
            for (int i = 0; i < OB - 1; i++) begin
                f_reg[i+1] <= f_cur[i];
            end
        end
    end

    assign code = c_reg[OB];

endmodule
`default_nettype wire

// ===== sv/ftg_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftg_merge
// Output stage: takes the merged lane codes into an output register with a
// skid entry, so the pipeline sees a registered ready.
// ----------------------------------------------------------------------------
module ftg_merge #(
    parameter int DATA_W = 24
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [DATA_W-1:0] in_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [DATA_W-1:0]      m_data
);
    import ftg_pkg::*;

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic [DATA_W-1:0] skid_data_reg, skid_data_next;
    logic              in_take;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        in_take         = in_valid && !skid_valid_reg;
        if (skid_valid_reg) begin
            if (m_ready) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (in_take) begin
            if (!out_valid_reg || m_ready) begin
                out_data_next  = in_data;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next  = in_data;
                skid_valid_next = 1'b1;
            end
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready = !skid_valid_reg;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

endmodule
`default_nettype wire

// ===== sv/ftg_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftg_checker
// Port-level checks for the filmic tone mapper, bound to the top level.
// ----------------------------------------------------------------------------
module ftg_checker #(
    parameter  int IN_BITS  = ftg_pkg::IN_BITS_DEF,
    parameter  int OUT_BITS = ftg_pkg::OUT_BITS_DEF,
    localparam int IN_W     = ((3 * IN_BITS + 7) / 8) * 8,
    localparam int OUT_W    = ((3 * OUT_BITS + 7) / 8) * 8
) (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [IN_W-1:0]                s_tdata,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [OUT_W-1:0]               m_tdata,
    input wire logic                           psel,
    input wire logic                           penable,
    input wire logic                           pwrite,
    input wire logic [ftg_pkg::CFG_ADDR_W-1:0] paddr,
    input wire logic [ftg_pkg::CFG_DATA_W-1:0] pwdata,
    input wire logic [ftg_pkg::CFG_DATA_W-1:0] prdata,
    input wire logic                           pready
);
    import ftg_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result word changed while stalled");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result word pending");

    a_gain_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && pready
        && (paddr[CFG_ADDR_W-1:2] == REG_GAIN_IDX)
        |=> prdata == CFG_DATA_W'($past(pwdata[GAIN_W-1:0])))
        else $error("exposure gain readback mismatch");

    logic unused_ok;
    assign unused_ok = s_tvalid ^ (^s_tdata);

endmodule

bind filmic_tonemap_gamma ftg_checker #(
    .IN_BITS  (IN_BITS),
    .OUT_BITS (OUT_BITS)
) u_ftg_checker (.*);
`default_nettype wire
